[rtl/core/bhns_pkg.sv]
// ----------------------------------------------------------------------------
// bhns_pkg: shared types and constants for the best heading neighbour select
// Holds the beat structs on each side, the queue entry and the number ranges.
// ----------------------------------------------------------------------------
package bhns_pkg;

	localparam int unsigned TreeNodesDefault = 65536;
	localparam int unsigned DiffW = 33;   // sample minus position
	localparam int unsigned SqW   = 68;   // sum of three squares
	localparam int unsigned NumW  = 66;   // magnitude of the dot product
	localparam int unsigned LenW  = 34;   // integer square root

	typedef struct packed {
		logic signed [31:0] sample_x;
		logic signed [31:0] sample_y;
		logic signed [31:0] sample_z;
		logic signed [31:0] node_pos_x;
		logic signed [31:0] node_pos_y;
		logic signed [31:0] node_pos_z;
		logic signed [31:0] node_vel_x;
		logic signed [31:0] node_vel_y;
		logic signed [31:0] node_vel_z;
		logic        [15:0] node_index;
		logic               last_candidate;
	} in_beat_t;

	typedef struct packed {
		logic        [15:0] best_index;
		logic signed [31:0] best_score;
	} out_beat_t;

	// classified work handed from front to back
	typedef struct packed {
		logic signed [DiffW-1:0] dx;
		logic signed [DiffW-1:0] dy;
		logic signed [DiffW-1:0] dz;
		logic signed [31:0]      vx;
		logic signed [31:0]      vy;
		logic signed [31:0]      vz;
		logic        [15:0]      idx;
		logic                    scored;   // index inside the tree
		logic                    last;
	} job_t;

endpackage

[rtl/core/bhns_front.sv]
// ----------------------------------------------------------------------------
// bhns_front: input stage
// Registers the input beat, forms the direction and checks the index range.
// ----------------------------------------------------------------------------
module bhns_front import bhns_pkg::*; #(
	parameter int unsigned TREE_NODES = TreeNodesDefault
) (
	input  logic     clk,
	input  logic     arst_n,
	input  in_beat_t in_beat,
	input  logic     push,
	output logic     full,
	output job_t     job,
	output logic     job_valid,
	input  logic     job_take
);
	logic valid_q;
	job_t job_q;
	logic in_range;

	// node_index is 16 bits; compare against the tree size in a 32 bit space
	assign in_range = ({16'd0, in_beat.node_index} < 32'(TREE_NODES));
	assign full = valid_q && !job_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push && !full) begin
			valid_q <= 1'b1;
		end else if (job_take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			job_q.dx     <= DiffW'(in_beat.sample_x) - DiffW'(in_beat.node_pos_x);
			job_q.dy     <= DiffW'(in_beat.sample_y) - DiffW'(in_beat.node_pos_y);
			job_q.dz     <= DiffW'(in_beat.sample_z) - DiffW'(in_beat.node_pos_z);
			job_q.vx     <= in_beat.node_vel_x;
			job_q.vy     <= in_beat.node_vel_y;
			job_q.vz     <= in_beat.node_vel_z;
			job_q.idx    <= in_beat.node_index;
			job_q.scored <= in_range;
			job_q.last   <= in_beat.last_candidate;
		end
	end

	assign job = job_q;
	assign job_valid = valid_q;
endmodule

[rtl/core/bhns_queue.sv]
// ----------------------------------------------------------------------------
// bhns_queue: two-entry queue between front and back
// Lets the front take a new beat while the back is still busy.
// ----------------------------------------------------------------------------
module bhns_queue import bhns_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  job_t wr_job,
	input  logic wr_valid,
	output logic wr_take,
	output job_t rd_job,
	output logic rd_valid,
	input  logic rd_take
);
	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign wr_take  = wr_valid && (cnt_q != 2'd2);
	assign wr       = wr_take;
	assign rd       = rd_take && (cnt_q != 2'd0);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_job   = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_job;
	end
endmodule

[rtl/core/bhns_back.sv]
// ----------------------------------------------------------------------------
// bhns_back: scoring engine
// Squares and dot product over three multiply steps, bit serial square root,
// restoring division, saturation, running best and a result queue slot.
// ----------------------------------------------------------------------------
module bhns_back import bhns_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  job_t      job,
	input  logic      job_valid,
	output logic      job_take,
	output out_beat_t res,
	output logic      res_valid,
	input  logic      res_take
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_SQRT, ST_DIV, ST_SAT, ST_DONE
	} state_t;

	state_t            state_q;
	job_t              job_q;
	logic [1:0]        axis_q;
	logic [SqW-1:0]    s_q;
	logic [NumW:0]     pos_q, neg_q;
	logic [NumW-1:0]   num_q;
	logic              negative_q;
	logic [LenW-1:0]   len_q;
	logic [LenW:0]     sq_rem_q;       // sqrt remainder scratch
	logic [SqW-1:0]    sq_src_q;
	logic [6:0]        cnt_q;
	logic [NumW-1:0]   quo_q;
	logic [LenW:0]     rem_q;
	logic signed [31:0] score_q;
	logic signed [31:0] best_score_q;
	logic [15:0]       best_index_q;
	logic              have_q;
	out_beat_t         res_q;
	logic              res_valid_q;

	// one axis per cycle
	logic signed [DiffW-1:0] d_sel;
	logic signed [31:0]      v_sel;
	logic [DiffW-1:0]        dm;
	logic [31:0]             vm;
	logic [65:0]             dd, dv;
	logic [NumW:0]           diff_pn;

	always_comb begin
		case (axis_q)
			2'd0:    begin d_sel = job_q.dx; v_sel = job_q.vx; end
			2'd1:    begin d_sel = job_q.dy; v_sel = job_q.vy; end
			default: begin d_sel = job_q.dz; v_sel = job_q.vz; end
		endcase
		dm = d_sel[DiffW-1] ? DiffW'(-d_sel) : DiffW'(d_sel);
		vm = v_sel[31] ? 32'(-v_sel) : 32'(v_sel);
		dd = 66'(dm) * 66'(dm);
		dv = 66'(dm) * 66'(vm);
		diff_pn = pos_q - neg_q;
	end

	// square root: two bits of the radicand per step
	logic [LenW+2:0] sq_trial;
	logic [LenW+2:0] sq_next;
	always_comb begin
		sq_next  = {sq_rem_q, sq_src_q[SqW-1 -: 2]};
		sq_trial = {1'b0, len_q, 2'b01};
	end

	// division: one quotient bit per step
	logic [LenW+1:0] rem_sh;
	always_comb begin
		rem_sh = {rem_q, num_q[NumW-1]};
	end

	// saturation
	logic [31:0] lim;
	logic        big;
	always_comb begin
		lim = negative_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
		big = (quo_q[NumW-1:32] != '0) || (quo_q[31:0] > lim);
	end

	logic [31:0] mag_sat;
	assign mag_sat = big ? lim : quo_q[31:0];

	assign job_take  = (state_q == ST_IDLE) && job_valid;
	assign res       = res_q;
	assign res_valid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			have_q       <= 1'b0;
			res_valid_q  <= 1'b0;
			best_score_q <= '0;
			best_index_q <= '0;
		end else begin
			if (res_take) res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						job_q  <= job;
						axis_q <= 2'd0;
						s_q    <= '0;
						pos_q  <= '0;
						neg_q  <= '0;
						state_q <= job.scored ? ST_MUL : ST_DONE;
					end
				end
				ST_MUL: begin
					s_q <= s_q + SqW'(dd);
					if (d_sel[DiffW-1] != v_sel[31]) neg_q <= neg_q + (NumW+1)'(dv);
					else                             pos_q <= pos_q + (NumW+1)'(dv);
					// steps to 3 after the last axis, marking the sqrt setup cycle
					axis_q <= axis_q + 2'd1;
					if (axis_q == 2'd2) begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (axis_q == 2'd3) begin
						// first sqrt cycle: set up
						if (s_q == '0) begin
							score_q <= '0;
							state_q <= ST_DONE;
						end
						negative_q <= diff_pn[NumW];
						num_q <= diff_pn[NumW] ? NumW'(neg_q - pos_q) : NumW'(diff_pn);
						sq_src_q <= s_q;
						sq_rem_q <= '0;
						len_q    <= '0;
						cnt_q    <= 7'd0;
						axis_q   <= 2'd0;
					end else begin
						sq_src_q <= {sq_src_q[SqW-3:0], 2'b00};
						if (sq_next >= sq_trial) begin
							sq_rem_q <= (LenW+1)'(sq_next - sq_trial);
							len_q    <= {len_q[LenW-2:0], 1'b1};
						end else begin
							sq_rem_q <= sq_next[LenW:0];
							len_q    <= {len_q[LenW-2:0], 1'b0};
						end
						cnt_q <= cnt_q + 7'd1;
						if (cnt_q == 7'(SqW/2 - 1)) begin
							cnt_q   <= 7'd0;
							rem_q   <= '0;
							quo_q   <= '0;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					num_q <= {num_q[NumW-2:0], 1'b0};
					if (rem_sh >= {2'b00, len_q}) begin
						rem_q <= (LenW+1)'(rem_sh - {2'b00, len_q});
						quo_q <= {quo_q[NumW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh[LenW:0];
						quo_q <= {quo_q[NumW-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'(NumW - 1)) state_q <= ST_SAT;
				end
				ST_SAT: begin
					score_q <= negative_q ? 32'(-mag_sat) : mag_sat;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!job_q.last || !res_valid_q || res_take) begin
						logic upd;
						logic nh;
						logic signed [31:0] bs;
						logic [15:0] bi;
						upd = job_q.scored && (!have_q || score_q > best_score_q);
						nh  = have_q || job_q.scored;
						bs  = upd ? score_q : best_score_q;
						bi  = upd ? job_q.idx : best_index_q;
						if (job_q.last) begin
							res_q.best_index <= nh ? bi : 16'd0;
							res_q.best_score <= nh ? bs : 32'sd0;
							res_valid_q  <= 1'b1;
							have_q       <= 1'b0;
							best_score_q <= '0;
							best_index_q <= '0;
						end else begin
							have_q       <= nh;
							best_score_q <= bs;
							best_index_q <= bi;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[rtl/core/best_heading_neighbour_select_unit.sv]
// ----------------------------------------------------------------------------
// best_heading_neighbour_select_unit: top level
// Scores candidate nodes by velocity along the unit direction to the sample.
// ----------------------------------------------------------------------------
// A scored candidate passes through the back engine in order: a take, a
// multiply step per axis, a setup, a square root (two radicand bits a step),
// a restoring division (one quotient bit a step), saturation and an update.
// A scored candidate at zero distance skips root, division and saturation. A
// candidate whose index is outside the tree goes from the take straight to
// the update. The front register and a two-entry queue let up to three beats
// wait while the engine works. One result beat per beat marked last, held in
// an output slot until popped; a last beat waits in its update step while
// the slot is still occupied.
module best_heading_neighbour_select_unit import bhns_pkg::*; #(
	parameter int unsigned TREE_NODES = TreeNodesDefault
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_beat_t  in_beat,
	input  logic      push,
	output logic      full,
	output out_beat_t out_beat,
	output logic      empty,
	input  logic      pop
);
	job_t f_job, q_job;
	logic f_valid, f_take, q_valid, q_take, r_valid;

	bhns_front #(.TREE_NODES(TREE_NODES)) u_front (
		.clk, .arst_n, .in_beat, .push, .full,
		.job(f_job), .job_valid(f_valid), .job_take(f_take)
	);

	bhns_queue u_queue (
		.clk, .arst_n,
		.wr_job(f_job), .wr_valid(f_valid), .wr_take(f_take),
		.rd_job(q_job), .rd_valid(q_valid), .rd_take(q_take)
	);

	bhns_back u_back (
		.clk, .arst_n,
		.job(q_job), .job_valid(q_valid), .job_take(q_take),
		.res(out_beat), .res_valid(r_valid), .res_take(pop)
	);

	assign empty = !r_valid;

	// the engine only takes work that the queue actually holds
	a_take: assert property (@(posedge clk) disable iff (!arst_n) q_take |-> q_valid)
		else $error("engine took from empty queue");
	// a waiting result beat stays put until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_beat)))
		else $error("result beat changed while waiting");
	// full never blocks when the front holds nothing
	a_full: assert property (@(posedge clk) disable iff (!arst_n) full |-> f_valid)
		else $error("full without held beat");
endmodule
